// ===== rtl/pws_pkg.sv =====
`default_nettype none
package pws_pkg;

    localparam int DEF_MAX_SITES    = 8;
    localparam int DEF_MAX_VIEWS    = 8;
    localparam int DEF_MAX_POINTS   = 512;
    localparam int DEF_WEIGHT_DEPTH = 16384;

    // Item kinds.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_PAIR   = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_WADDR = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID    = 3'd0;
    localparam logic [2:0] CFG_SITES_U = 3'd1;
    localparam logic [2:0] CFG_SITES_V = 3'd2;
    localparam logic [2:0] CFG_STRIDE  = 3'd3;
    localparam logic [2:0] CFG_REDUCED = 3'd4;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic load_x0;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

endpackage
`default_nettype wire

// ===== rtl/pws_store.sv =====
`default_nettype none
module pws_store import pws_pkg::*; #(
    parameter int SA_W = 15,
    parameter int WA_W = 14
) (
    input  wire logic            i_clk,
    input  wire logic            i_s_we,
    input  wire logic [SA_W-1:0] i_s_waddr,
    input  wire logic [31:0]     i_s_wdata,
    input  wire logic [SA_W-1:0] i_s_raddr,
    output logic [31:0]          o_s_rdata,
    input  wire logic            i_w_we,
    input  wire logic [WA_W-1:0] i_w_waddr,
    input  wire logic [31:0]     i_w_wdata,
    input  wire logic [WA_W-1:0] i_w_raddr,
    output logic [31:0]          o_w_rdata
);

    logic [31:0] r_sample [2**SA_W];
    logic [31:0] r_weight [2**WA_W];

    always_ff @(posedge i_clk) begin
        if (i_s_we) begin
            r_sample[i_s_waddr] <= i_s_wdata;
        end
        o_s_rdata <= r_sample[i_s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_weight[i_w_waddr] <= i_w_wdata;
        end
        o_w_rdata <= r_weight[i_w_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pws_pair_tab.sv =====
`default_nettype none
module pws_pair_tab import pws_pkg::*; #(
    parameter int PA_W = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [PA_W-1:0] i_waddr,
    input  wire logic [13:0]     i_base,
    input  wire logic [9:0]      i_len,
    input  wire logic [9:0]      i_rlen,
    input  wire logic [PA_W-1:0] i_raddr,
    output logic [13:0]          o_base,
    output logic [9:0]           o_len,
    output logic [9:0]           o_rlen
);

    logic [33:0] r_tab [2**PA_W];
    logic [33:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tab[i_waddr] <= {i_base, i_len, i_rlen};
        end
        r_rd <= r_tab[i_raddr];
    end

    assign o_base = r_rd[33:20];
    assign o_len  = r_rd[19:10];
    assign o_rlen = r_rd[9:0];

endmodule
`default_nettype wire

// ===== rtl/pws_mac.sv =====
`default_nettype none
module pws_mac import pws_pkg::*; #(
    parameter int ACC_W = 70
) (
    input  wire logic        i_clk,
    input  wire t_mac_ctrl   i_ctrl,
    input  wire logic [31:0] i_x,
    input  wire logic [31:0] i_w,
    output logic [31:0]      o_value,
    output logic             o_sat
);

    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    all_zero;
    logic                    all_one;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= $signed(i_w) * $signed(i_x);
        end
        // The rounding constant is folded in when the own sample is loaded.
        if (i_ctrl.load_x0) begin
            r_acc <= ($signed(ACC_W'($signed(i_x))) <<< 30)
                     + $signed(ACC_W'(64'sd1 <<< 29));
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign all_zero = (r_acc[ACC_W-1:61] == '0);
    assign all_one  = (r_acc[ACC_W-1:61] == '1);
    assign o_sat    = !(all_zero || all_one);
    assign o_value  = o_sat ? (r_acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                            : r_acc[61:30];

endmodule
`default_nettype wire

// ===== rtl/pair_weighted_site_mix.sv =====
`default_nettype none
// Pairwise weighted site mixer. Load items (sample, weight, pair entry) are taken
// while no query is in flight and write straight into on-chip memories. A query
// for site u, view v and point i returns x[u,v,i] plus weight*x[j,v,i] for every
// other site j below sites_u whose pair length covers i, rounded half up to
// Q16.16 and saturated. A query in range first reads its own sample; then, per
// site below sites_u, it skips the queried site itself, reads the pair table and
// checks a partner that has no term or whose weight address falls outside the
// store, and for a partner that contributes reads the pair table, reads weight
// and sample, multiplies and accumulates. A query out of range goes straight to
// its result. Each memory has a single read port. One query is in flight at a
// time; a finished result sits in the output register while the next item is
// taken.
// Stores are not cleared by reset and must be loaded before they are queried.
module pair_weighted_site_mix import pws_pkg::*; #(
    parameter int MAX_SITES    = DEF_MAX_SITES,
    parameter int MAX_VIEWS    = DEF_MAX_VIEWS,
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [2:0]  i_site,
    input  wire logic [2:0]  i_view,
    input  wire logic [8:0]  i_point,
    input  wire logic [31:0] i_sample_value,
    input  wire logic [13:0] i_weight_address,
    input  wire logic [31:0] i_weight_value,
    input  wire logic [4:0]  i_pair_index,
    input  wire logic [13:0] i_entry_base,
    input  wire logic [9:0]  i_entry_length,
    input  wire logic [9:0]  i_entry_reduced_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result_value,
    output logic [1:0]       o_status
);

    localparam int SA_W  = $clog2(MAX_SITES * MAX_VIEWS * MAX_POINTS);
    localparam int WA_W  = $clog2(WEIGHT_DEPTH);
    localparam int PC    = MAX_SITES * (MAX_SITES - 1) / 2;
    localparam int PA_W  = (PC > 1) ? $clog2(PC) : 1;
    localparam int JW    = $clog2(MAX_SITES) + 1;
    localparam int ACC_W = 66 + $clog2(MAX_SITES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_X0   = 3'd1;
    localparam logic [2:0] S_J    = 3'd2;
    localparam logic [2:0] S_PR   = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_AC   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Configuration registers.
    logic [9:0] r_grid;
    logic [3:0] r_sites_u;
    logic [3:0] r_sites_v;
    logic [4:0] r_stride;
    logic       r_reduced;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid    <= 10'd512;
            r_sites_u <= 4'd8;
            r_sites_v <= 4'd8;
            r_stride  <= 5'd1;
            r_reduced <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID:    r_grid    <= i_cfg_data;
                CFG_SITES_U: r_sites_u <= i_cfg_data[3:0];
                CFG_SITES_V: r_sites_v <= i_cfg_data[3:0];
                CFG_STRIDE:  r_stride  <= i_cfg_data[4:0];
                CFG_REDUCED: r_reduced <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_u, r_v;
    logic [8:0]    r_i;
    logic [JW-1:0] r_j, n_j;
    logic          r_fault, n_fault;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [1:0]    r_ostat;
    logic          r_x0_pend;
    logic          r_range_bad;

    logic accept;
    logic out_free;
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    function automatic logic [3:0] sites_lim();
        return (32'(r_sites_u) > MAX_SITES) ? 4'(MAX_SITES) : r_sites_u;
    endfunction

    // Load write enables and range checks.
    logic s_we, w_we, p_we, q_range_ok;
    assign s_we = accept && (i_kind == KIND_SAMPLE) && (32'(i_site) < MAX_SITES)
                  && (32'(i_view) < MAX_VIEWS) && (32'(i_point) < MAX_POINTS);
    assign w_we = accept && (i_kind == KIND_WEIGHT)
                  && (32'(i_weight_address) < WEIGHT_DEPTH);
    assign p_we = accept && (i_kind == KIND_PAIR) && (32'(i_pair_index) < PC);
    assign q_range_ok = (4'(i_site) < sites_lim()) && (32'(i_view) < MAX_VIEWS)
                        && (32'(i_view) < 32'(r_sites_v)) && (32'(i_point) < MAX_POINTS)
                        && (10'(i_point) < r_grid);

    logic [SA_W-1:0] load_saddr;
    assign load_saddr = SA_W'((32'(i_site) * MAX_VIEWS + 32'(i_view)) * MAX_POINTS
                              + 32'(i_point));

    // Sample read address: the own sample in S_X0, the partner's in S_PR.
    logic [SA_W-1:0] rd_saddr;
    logic [2:0]      rd_site;
    assign rd_site  = (r_state == S_X0) ? r_u : 3'(r_j);
    assign rd_saddr = SA_W'((32'(rd_site) * MAX_VIEWS + 32'(r_v)) * MAX_POINTS
                            + 32'(r_i));

    // Triangular pair number of (j, u).
    logic [31:0]     pm, pmn;
    logic [PA_W-1:0] pair_raddr;
    assign pm  = (32'(r_j) > 32'(r_u)) ? 32'(r_j) : 32'(r_u);
    assign pmn = (32'(r_j) > 32'(r_u)) ? 32'(r_u) : 32'(r_j);
    assign pair_raddr = PA_W'(((pm * (pm - 32'd1)) >> 1) + pmn);

    logic [13:0] pt_base;
    logic [9:0]  pt_len, pt_rlen;

    // Weight address of the current partner.
    logic [9:0]  use_len;
    logic [16:0] red_sum, waddr_full;
    logic        waddr_neg, waddr_bad, term_on;
    assign use_len   = r_reduced ? pt_rlen : pt_len;
    assign term_on   = (10'(r_i) < use_len);
    assign red_sum   = 17'(pt_base) + 17'(r_stride) * (17'(r_i) + 17'd1);
    assign waddr_neg = r_reduced && (red_sum == '0);
    assign waddr_full = r_reduced ? (red_sum - 17'd1) : (17'(pt_base) + 17'(r_i));
    assign waddr_bad = waddr_neg || (32'(waddr_full) >= WEIGHT_DEPTH);

    logic [WA_W-1:0] w_raddr;
    assign w_raddr = WA_W'(waddr_full);

    logic [31:0] s_rdata, w_rdata;

    pws_store #(.SA_W(SA_W), .WA_W(WA_W)) u_store (
        .i_clk     (i_clk),
        .i_s_we    (s_we),
        .i_s_waddr (load_saddr),
        .i_s_wdata (i_sample_value),
        .i_s_raddr (rd_saddr),
        .o_s_rdata (s_rdata),
        .i_w_we    (w_we),
        .i_w_waddr (WA_W'(i_weight_address)),
        .i_w_wdata (i_weight_value),
        .i_w_raddr (w_raddr),
        .o_w_rdata (w_rdata)
    );

    pws_pair_tab #(.PA_W(PA_W)) u_pair (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (PA_W'(i_pair_index)),
        .i_base  (i_entry_base),
        .i_len   (i_entry_length),
        .i_rlen  (i_entry_reduced_length),
        .i_raddr (pair_raddr),
        .o_base  (pt_base),
        .o_len   (pt_len),
        .o_rlen  (pt_rlen)
    );

    t_mac_ctrl   mac_ctrl;
    logic [31:0] mac_value;
    logic        mac_sat;

    pws_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_x     (s_rdata),
        .i_w     (w_rdata),
        .o_value (mac_value),
        .o_sat   (mac_sat)
    );

    // Sequencer: one partner site per pass through S_J.
    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_fault  = r_fault;
        mac_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_QUERY)) begin
                    n_j     = '0;
                    n_fault = 1'b0;
                    n_state = q_range_ok ? S_X0 : S_FIN;
                end
            end
            S_X0: begin
                n_state = S_J;
            end
            S_J: begin
                if (32'(r_j) >= 32'(sites_lim())) begin
                    n_state = S_FIN;
                end else if (3'(r_j) == r_u) begin
                    n_j = r_j + JW'(1);
                end else begin
                    n_state = S_PR;
                end
            end
            S_PR: begin
                if (!term_on) begin
                    n_j     = r_j + JW'(1);
                    n_state = S_J;
                end else if (waddr_bad) begin
                    n_fault = 1'b1;
                    n_j     = r_j + JW'(1);
                    n_state = S_J;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mac_ctrl.mul_en = 1'b1;
                n_state = S_AC;
            end
            S_AC: begin
                mac_ctrl.acc_en = 1'b1;
                n_j     = r_j + JW'(1);
                n_state = S_J;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // The own sample arrives in the cycle after its read in S_X0.
        if (r_state == S_J && r_j == JW'(0) && r_x0_pend) begin
            mac_ctrl.load_x0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_x0_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_x0_pend <= (r_state == S_X0);
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_fault <= n_fault;
        if (accept) begin
            r_u         <= i_site;
            r_v         <= i_view;
            r_i         <= i_point;
            r_range_bad <= !q_range_ok;
        end
        if (r_state == S_FIN && out_free) begin
            priority if (r_range_bad) begin
                r_oval  <= '0;
                r_ostat <= ST_RANGE;
            end else if (r_fault) begin
                r_oval  <= '0;
                r_ostat <= ST_WADDR;
            end else begin
                r_oval  <= mac_value;
                r_ostat <= mac_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_status       = r_ostat;

endmodule
`default_nettype wire
